### hw/rtl/hkra_pkg.sv
// ----------------------------------------------------------------------------
// HID keyboard report line assembler: shared package
// Types and fixed constants used by the lanes, the merge stage and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package hkra_pkg;

	// Field widths fixed by the report and character formats.
	localparam int KEY_W    = 8;
	localparam int CHAR_W   = 7;
	localparam int LEN_W    = 6;
	localparam int COUNT_W  = 3;
	localparam int MOD_W    = 8;
	localparam int KEY_PORTS = 6;

	// Modifier bits that mean shift (left and right shift).
	localparam logic [MOD_W-1:0] SHIFT_MASK = 8'h22;

	// HID usage codes of interest.
	localparam logic [KEY_W-1:0] KEY_LETTER_FIRST = 8'h04;
	localparam logic [KEY_W-1:0] KEY_LETTER_LAST  = 8'h1D;
	localparam logic [KEY_W-1:0] KEY_DIGIT_FIRST  = 8'h1E;
	localparam logic [KEY_W-1:0] KEY_DIGIT_LAST   = 8'h27;
	localparam logic [KEY_W-1:0] KEY_ENTER        = 8'h28;
	localparam logic [KEY_W-1:0] KEY_SPACE        = 8'h2C;
	localparam logic [KEY_W-1:0] KEY_MINUS        = 8'h2D;
	localparam logic [KEY_W-1:0] KEY_EQUAL        = 8'h2E;
	localparam logic [KEY_W-1:0] KEY_COMMA        = 8'h36;
	localparam logic [KEY_W-1:0] KEY_PERIOD       = 8'h37;
	localparam logic [KEY_W-1:0] KEY_SLASH        = 8'h38;

	localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;

	// Reset value of the minimum code length register.
	localparam logic [LEN_W-1:0] MIN_LEN_RESET = 6'd4;

	// What one key slot contributes.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_CHAR,
		KIND_ENTER
	} key_kind_t;

	typedef struct packed {
		key_kind_t         kind;
		logic [CHAR_W-1:0] ch;
	} lane_res_t;

	// One emitted character with its run information.
	typedef struct packed {
		logic [CHAR_W-1:0] code_char;
		logic              last_char;
		logic [LEN_W-1:0]  code_length;
		logic              overflowed;
	} char_res_t;

endpackage

`default_nettype wire

### hw/rtl/hkra_if.sv
// ----------------------------------------------------------------------------
// HID keyboard report line assembler: channel interfaces
// Report channel into the block and character channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface hkra_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] modifier;
	logic [2:0] key_count;
	logic [7:0] key_0;
	logic [7:0] key_1;
	logic [7:0] key_2;
	logic [7:0] key_3;
	logic [7:0] key_4;
	logic [7:0] key_5;

	modport source (
		output valid, modifier, key_count, key_0, key_1, key_2, key_3, key_4, key_5,
		input  ready
	);
	modport sink (
		input  valid, modifier, key_count, key_0, key_1, key_2, key_3, key_4, key_5,
		output ready
	);
endinterface

interface hkra_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] code_char;
	logic       last_char;
	logic [5:0] code_length;
	logic       overflowed;

	modport source (
		output valid, code_char, last_char, code_length, overflowed,
		input  ready
	);
	modport sink (
		input  valid, code_char, last_char, code_length, overflowed,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/hkra_lane.sv
// ----------------------------------------------------------------------------
// HID keyboard report line assembler: key lane
// Maps one HID usage code to an ASCII character, an Enter mark or nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module hkra_lane (
	input  wire logic [7:0]         key,
	input  wire logic               shift,
	input  wire logic               enable,
	output hkra_pkg::lane_res_t     res
);
	import hkra_pkg::*;

	localparam logic [CHAR_W-1:0] DIGIT_PLAIN [10] = '{
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
	};
	localparam logic [CHAR_W-1:0] DIGIT_SHIFT [10] = '{
		7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29
	};

	logic [KEY_W-1:0]  letter_lc;
	logic [3:0]        digit_idx;

	// Lower case letter is 'a' plus the offset from the first letter code.
	assign letter_lc = KEY_W'(key - KEY_LETTER_FIRST + 8'h61);
	assign digit_idx = 4'(key - KEY_DIGIT_FIRST);

	// Decode the usage code; zero codes and disabled slots give nothing.
	always_comb begin
		res.kind = KIND_NONE;
		res.ch   = '0;
		if (enable && key != '0) begin
			if (key >= KEY_LETTER_FIRST && key <= KEY_LETTER_LAST) begin
				res.kind = KIND_CHAR;
				res.ch   = shift ? CHAR_W'(letter_lc - 8'd32) : CHAR_W'(letter_lc);
			end else if (key >= KEY_DIGIT_FIRST && key <= KEY_DIGIT_LAST) begin
				res.kind = KIND_CHAR;
				res.ch   = shift ? DIGIT_SHIFT[digit_idx] : DIGIT_PLAIN[digit_idx];
			end else begin
				unique case (key)
					KEY_ENTER: begin
						res.kind = KIND_ENTER;
					end
					KEY_SPACE: begin
						res.kind = KIND_CHAR;
						res.ch   = ASCII_SPACE;
					end
					KEY_MINUS: begin
						res.kind = KIND_CHAR;
						res.ch   = shift ? 7'h5F : 7'h2D;
					end
					KEY_EQUAL: begin
						res.kind = KIND_CHAR;
						res.ch   = shift ? 7'h2B : 7'h3D;
					end
					KEY_COMMA: begin
						res.kind = KIND_CHAR;
						res.ch   = shift ? 7'h3C : 7'h2C;
					end
					KEY_PERIOD: begin
						res.kind = KIND_CHAR;
						res.ch   = shift ? 7'h3E : 7'h2E;
					end
					KEY_SLASH: begin
						res.kind = KIND_CHAR;
						res.ch   = shift ? 7'h3F : 7'h2F;
					end
					default: begin
						res.kind = KIND_NONE;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/hkra_merge.sv
// ----------------------------------------------------------------------------
// HID keyboard report line assembler: merge stage
// Walks the lane results in slot order, builds the code in a character
// store and plays a completed code out through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hkra_merge #(
	parameter int MAX_CODE_CHARS = 32,
	parameter int KEY_SLOTS      = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire hkra_pkg::lane_res_t   lanes [KEY_SLOTS],
	input  wire logic [5:0]            min_len,
	output logic                       idle,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output hkra_pkg::char_res_t        out_res
);
	import hkra_pkg::*;

	localparam int ADDR_W = $clog2(MAX_CODE_CHARS);
	localparam int CNT_W  = $clog2(MAX_CODE_CHARS + 1);
	localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SCAN    = 2'd1;
	localparam logic [1:0] ST_EMIT_RD = 2'd2;
	localparam logic [1:0] ST_EMIT_WR = 2'd3;

	logic [1:0]        state_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  trim_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  k_q;
	logic              emit_ovf_q;
	logic              resume_last_q;
	logic              out_valid_q;
	char_res_t         out_res_q;

	logic [CHAR_W-1:0] store_mem [MAX_CODE_CHARS];
	logic [CHAR_W-1:0] rd_data_s1;

	lane_res_t         cur;
	logic              last_slot;
	logic              is_space;
	logic              keep_char;
	logic              full;
	logic              wr_en;
	logic              emit_go;
	logic [CNT_W-1:0]  k_next;
	logic              k_done;

	assign cur       = lanes[slot_q];
	assign last_slot = (slot_q == SLOT_W'(KEY_SLOTS - 1));
	assign is_space  = (cur.ch == ASCII_SPACE);
	assign full      = (fill_q >= CNT_W'(MAX_CODE_CHARS));
	// A leading space is dropped before any room check.
	assign keep_char = (cur.kind == KIND_CHAR) && !(is_space && fill_q == '0);
	assign wr_en     = (state_q == ST_SCAN) && keep_char && !full;
	assign emit_go   = (cur.kind == KIND_ENTER) && (trim_q != '0)
		&& (CMP_W'(trim_q) >= CMP_W'(min_len));
	assign k_next    = k_q + CNT_W'(1);
	assign k_done    = (k_next == len_q);

	// Character store: one write port while scanning, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[fill_q[ADDR_W-1:0]] <= cur.ch;
		end
		rd_data_s1 <= store_mem[k_q[ADDR_W-1:0]];
	end

	// Slot sequencer and code buffer bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			slot_q        <= '0;
			fill_q        <= '0;
			trim_q        <= '0;
			ovf_q         <= 1'b0;
			len_q         <= '0;
			k_q           <= '0;
			emit_ovf_q    <= 1'b0;
			resume_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						slot_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					case (cur.kind)
						KIND_CHAR: begin
							if (keep_char) begin
								if (full) begin
									ovf_q <= 1'b1;
								end else begin
									fill_q <= fill_q + CNT_W'(1);
									if (!is_space) begin
										trim_q <= fill_q + CNT_W'(1);
									end
								end
							end
						end
						KIND_ENTER: begin
							len_q         <= trim_q;
							emit_ovf_q    <= ovf_q;
							k_q           <= '0;
							resume_last_q <= last_slot;
							fill_q        <= '0;
							trim_q        <= '0;
							ovf_q         <= 1'b0;
						end
						default: begin
						end
					endcase
					if (emit_go) begin
						state_q <= ST_EMIT_RD;
					end else if (last_slot) begin
						state_q <= ST_IDLE;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				ST_EMIT_RD: begin
					// Read only once the output register is free by the next edge.
					if (!out_valid_q || out_ready) begin
						state_q <= ST_EMIT_WR;
					end
				end
				ST_EMIT_WR: begin
					k_q <= k_next;
					if (!k_done) begin
						state_q <= ST_EMIT_RD;
					end else if (resume_last_q) begin
						state_q <= ST_IDLE;
					end else begin
						slot_q  <= slot_q + SLOT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT_WR) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_WR) begin
			out_res_q.code_char   <= rd_data_s1;
			out_res_q.last_char   <= k_done;
			out_res_q.code_length <= LEN_W'(len_q);
			out_res_q.overflowed  <= emit_ovf_q;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_CODE_CHARS))
		else $error("character count exceeds the store depth");
	a_trim_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		trim_q <= fill_q)
		else $error("trimmed end lies beyond the filled characters");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_WR |-> !out_valid_q)
		else $error("output register loaded while still holding a character");
	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_WR) |-> (k_q < len_q))
		else $error("emit index ran past the code length");
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_WR && k_done) |=> out_res_q.last_char)
		else $error("final character of a run not marked");
`endif

endmodule

`default_nettype wire

### hw/rtl/hid_keyboard_report_line_assembler.sv
// ----------------------------------------------------------------------------
// HID keyboard report line assembler: top level
// Turns boot-keyboard reports into runs of ASCII characters, one run per
// completed, non-empty code line of at least the minimum code length.
// ----------------------------------------------------------------------------
// Usage
//   report: one boot-keyboard request per report (modifier, key_count and
//     six usage codes). The block takes it when idle; it may take a new
//     report while the last character of a run still waits at the output.
//   chars: one request per emitted character, with last_char marking the
//     end of a code and code_length and overflowed repeated on each.
//   cfg_wr_en / cfg_wr_data: write the minimum code length; write only
//     while no report is in progress.
// Sequence
//   A report is captured into the lane result register, then the merge stage
//   walks the slots (one slot per cycle while it is not emitting), and each
//   emitted character takes a registered read of the character store and
//   then a load of the output register. A new report is taken only once the
//   merge stage is idle again after the last report.
// Reset clears the code buffer, the output valid flag and the sequencer and
//   sets the minimum length to 4; the store contents are not cleared.
// When the receiver stalls, the merge stage waits before its next store
//   read and the output register holds its character.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_keyboard_report_line_assembler #(
	parameter int MAX_CODE_CHARS = 32,
	parameter int KEY_SLOTS      = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	hkra_in_if.sink          report,
	hkra_out_if.source       chars,
	input  wire logic        cfg_wr_en,
	input  wire logic [5:0]  cfg_wr_data
);
	import hkra_pkg::*;

	logic [KEY_W-1:0]   keys [KEY_PORTS];
	logic               shift;
	logic [COUNT_W-1:0] count;
	lane_res_t          lane_res [KEY_SLOTS];
	lane_res_t          lane_s1 [KEY_SLOTS];
	logic               start_s1;
	logic [LEN_W-1:0]   min_len_q;
	logic               merge_idle;
	logic               accept;
	char_res_t          out_res;

	assign keys[0] = report.key_0;
	assign keys[1] = report.key_1;
	assign keys[2] = report.key_2;
	assign keys[3] = report.key_3;
	assign keys[4] = report.key_4;
	assign keys[5] = report.key_5;

	// Either shift bit selects the shifted character set.
	assign shift = |(report.modifier & SHIFT_MASK);
	// A slot count above the lane count is clipped.
	assign count = (report.key_count > COUNT_W'(KEY_SLOTS)) ? COUNT_W'(KEY_SLOTS)
		: report.key_count;

	// One decoding lane per key slot.
	for (genvar s = 0; s < KEY_SLOTS; s++) begin : g_lane
		hkra_lane u_lane (
			.key    (keys[s]),
			.shift  (shift),
			.enable (COUNT_W'(s) < count),
			.res    (lane_res[s])
		);
	end

	// Report handshake: take a report only when the merge stage is free.
	assign report.ready = merge_idle && !start_s1;
	assign accept       = report.valid && report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lane_s1 <= lane_res;
		end
	end

	// Minimum code length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
		end else if (cfg_wr_en) begin
			min_len_q <= cfg_wr_data;
		end
	end

	hkra_merge #(
		.MAX_CODE_CHARS (MAX_CODE_CHARS),
		.KEY_SLOTS      (KEY_SLOTS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_s1),
		.lanes     (lane_s1),
		.min_len   (min_len_q),
		.idle      (merge_idle),
		.out_valid (chars.valid),
		.out_ready (chars.ready),
		.out_res   (out_res)
	);

	assign chars.code_char   = out_res.code_char;
	assign chars.last_char   = out_res.last_char;
	assign chars.code_length = out_res.code_length;
	assign chars.overflowed  = out_res.overflowed;

endmodule

`default_nettype wire
